// ===== design/assert_macros.svh =====
// Assertion macros shared by the record parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every clock edge outside reset.
`define TRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check at every clock edge, reset included.
`define TRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/trp_pkg.sv =====
// Types and constants of the tab-separated record parser.
`default_nettype none

package trp_pkg;

  localparam int NAME_CHARS = 64;
  localparam int DESC_CHARS = 512;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [9:0] NAME_LIMIT = 10'(NAME_CHARS - 1);
  localparam logic [8:0] DESC_LIMIT = 9'(DESC_CHARS - 1);

  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] VT_BYTE    = 8'h0B;
  localparam logic [7:0] FF_BYTE    = 8'h0C;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] PLUS_BYTE  = 8'h2B;
  localparam logic [7:0] MINUS_BYTE = 8'h2D;
  localparam logic [7:0] ZERO_BYTE  = 8'h30;
  localparam logic [7:0] NINE_BYTE  = 8'h39;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  localparam logic [3:0] LAST_TEXT_COL   = 4'd7;
  localparam logic [3:0] FIRST_NUM_COL   = 4'd8;
  localparam logic [3:0] LAST_NUM_COL    = 4'd10;
  localparam logic [3:0] STRAND_COL      = 4'd11;
  localparam logic [3:0] DESC_COL        = 4'd15;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    KIND_CHAR       = 3'd0,
    KIND_FIELD_END  = 3'd1,
    KIND_NUMBER     = 3'd2,
    KIND_STRAND     = 3'd3,
    KIND_RECORD_END = 3'd4,
    KIND_OVERFLOW   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_BLANKS = 2'd0,
    PHASE_DIGITS = 2'd1,
    PHASE_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field_index;
    logic [7:0]  char_out;
    logic [8:0]  field_length;
    logic        is_number;
    logic        negative;
    logic [31:0] magnitude;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/trp_front.sv =====
// Front end: accepts bytes, tracks columns and fields, emits result commands.
`default_nettype none

module trp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_stall,
  input  wire logic [7:0]    byte_in,
  input  wire logic          queue_full,
  output logic               push,
  output trp_pkg::cmd_t      cmd
);

  `include "assert_macros.svh"

  logic [3:0]       column, column_next;
  logic [8:0]       char_count, char_count_next;
  logic [31:0]      accumulator, accumulator_next;
  logic             negative, negative_next;
  trp_pkg::phase_t  convert_phase, convert_phase_next;
  logic [7:0]       strand_char, strand_char_next;
  logic             skip_to_newline, skip_to_newline_next;

  logic             accept;
  logic [9:0]       count_inc;
  logic             is_digit;
  logic             is_blank;
  logic             is_sign;
  logic [35:0]      acc_times_ten;
  logic [31:0]      acc_sat;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;
  assign count_inc  = {1'b0, char_count} + 10'd1;
  assign is_digit   = (byte_in >= trp_pkg::ZERO_BYTE) && (byte_in <= trp_pkg::NINE_BYTE);
  assign is_blank   = (byte_in == trp_pkg::SPACE_BYTE) || (byte_in == trp_pkg::VT_BYTE) ||
                      (byte_in == trp_pkg::FF_BYTE) || (byte_in == trp_pkg::CR_BYTE);
  assign is_sign    = (byte_in == trp_pkg::PLUS_BYTE) || (byte_in == trp_pkg::MINUS_BYTE);
  assign acc_times_ten = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0} +
                         {32'd0, byte_in[3:0] - trp_pkg::ZERO_BYTE[3:0]};
  assign acc_sat = (acc_times_ten > {4'd0, trp_pkg::MAG_LIMIT}) ? trp_pkg::MAG_LIMIT
                                                                : acc_times_ten[31:0];

  always_comb begin
    column_next          = column;
    char_count_next      = char_count;
    accumulator_next     = accumulator;
    negative_next        = negative;
    convert_phase_next   = convert_phase;
    strand_char_next     = strand_char;
    skip_to_newline_next = skip_to_newline;
    push                 = 1'b0;
    cmd                  = '0;
    cmd.kind             = trp_pkg::KIND_CHAR;
    cmd.field_index      = column;

    if (accept) begin
      priority if (byte_in == trp_pkg::NL_BYTE) begin
        push     = 1'b1;
        cmd.kind = trp_pkg::KIND_RECORD_END;
        priority if (column <= trp_pkg::LAST_TEXT_COL || column == trp_pkg::DESC_COL) begin
          cmd.field_length = char_count;
        end else if (column <= trp_pkg::LAST_NUM_COL) begin
          cmd.is_number = 1'b1;
          cmd.negative  = negative;
          cmd.magnitude = accumulator;
        end else if (column == trp_pkg::STRAND_COL) begin
          cmd.char_out = strand_char;
        end else begin
          cmd.field_length = '0;
        end
        column_next          = '0;
        skip_to_newline_next = 1'b0;
        char_count_next      = '0;
        accumulator_next     = '0;
        negative_next        = 1'b0;
        convert_phase_next   = trp_pkg::PHASE_BLANKS;
        strand_char_next     = '0;
      end else if (skip_to_newline) begin
        push = 1'b0;
      end else if (column == trp_pkg::DESC_COL) begin
        priority if (byte_in == trp_pkg::NUL_BYTE) begin
          skip_to_newline_next = 1'b1;
        end else if (char_count < trp_pkg::DESC_LIMIT) begin
          char_count_next  = count_inc[8:0];
          push             = 1'b1;
          cmd.char_out     = byte_in;
          cmd.field_length = count_inc[8:0];
        end else begin
          push = 1'b0;
        end
      end else if (byte_in == trp_pkg::TAB_BYTE) begin
        column_next        = column + 4'd1;
        char_count_next    = '0;
        accumulator_next   = '0;
        negative_next      = 1'b0;
        convert_phase_next = trp_pkg::PHASE_BLANKS;
        strand_char_next   = '0;
        priority if (column <= trp_pkg::LAST_TEXT_COL) begin
          push             = 1'b1;
          cmd.kind         = trp_pkg::KIND_FIELD_END;
          cmd.field_length = char_count;
        end else if (column <= trp_pkg::LAST_NUM_COL) begin
          push          = 1'b1;
          cmd.kind      = trp_pkg::KIND_NUMBER;
          cmd.is_number = 1'b1;
          cmd.negative  = negative;
          cmd.magnitude = accumulator;
        end else if (column == trp_pkg::STRAND_COL) begin
          push         = 1'b1;
          cmd.kind     = trp_pkg::KIND_STRAND;
          cmd.char_out = strand_char;
        end else begin
          push = 1'b0;
        end
      end else if (column <= trp_pkg::LAST_NUM_COL) begin
        char_count_next = count_inc[8:0];
        priority if (count_inc >= trp_pkg::NAME_LIMIT) begin
          skip_to_newline_next = 1'b1;
          push                 = 1'b1;
          cmd.kind             = trp_pkg::KIND_OVERFLOW;
          cmd.char_out         = byte_in;
          cmd.field_length     = count_inc[8:0];
        end else if (column >= trp_pkg::FIRST_NUM_COL) begin
          unique case (convert_phase)
            trp_pkg::PHASE_BLANKS: begin
              priority if (is_blank) begin
                convert_phase_next = trp_pkg::PHASE_BLANKS;
              end else if (is_sign) begin
                negative_next      = (byte_in == trp_pkg::MINUS_BYTE);
                convert_phase_next = trp_pkg::PHASE_DIGITS;
              end else if (is_digit) begin
                convert_phase_next = trp_pkg::PHASE_DIGITS;
                accumulator_next   = acc_sat;
              end else begin
                convert_phase_next = trp_pkg::PHASE_DONE;
              end
            end
            trp_pkg::PHASE_DIGITS: begin
              if (is_digit) begin
                accumulator_next = acc_sat;
              end else begin
                convert_phase_next = trp_pkg::PHASE_DONE;
              end
            end
            default: begin
              convert_phase_next = convert_phase;
            end
          endcase
        end else begin
          push             = 1'b1;
          cmd.char_out     = byte_in;
          cmd.field_length = count_inc[8:0];
        end
      end else if (column == trp_pkg::STRAND_COL) begin
        if (char_count == '0) begin
          strand_char_next = byte_in;
          char_count_next  = 9'd1;
        end
      end else begin
        push = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      char_count      <= '0;
      accumulator     <= '0;
      negative        <= 1'b0;
      convert_phase   <= trp_pkg::PHASE_BLANKS;
      strand_char     <= '0;
      skip_to_newline <= 1'b0;
    end else begin
      column          <= column_next;
      char_count      <= char_count_next;
      accumulator     <= accumulator_next;
      negative        <= negative_next;
      convert_phase   <= convert_phase_next;
      strand_char     <= strand_char_next;
      skip_to_newline <= skip_to_newline_next;
    end
  end

  `TRP_ASSERT(a_newline_clears, accept && byte_in == trp_pkg::NL_BYTE |=> column == '0 && char_count == '0 && !skip_to_newline, "newline did not clear the record state")
  `TRP_ASSERT(a_overflow_skips, push && cmd.kind == trp_pkg::KIND_OVERFLOW |=> skip_to_newline, "overflow did not start the skip")
  `TRP_ASSERT(a_acc_bounded, accumulator <= trp_pkg::MAG_LIMIT, "accumulator beyond saturation limit")

endmodule

`default_nettype wire

// ===== design/trp_queue.sv =====
// Short command queue between the front end and the output stage.
`default_nettype none

module trp_queue #(
  parameter int DEPTH = trp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire trp_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output trp_pkg::cmd_t       head_cmd,
  output logic                full,
  output logic                empty
);

  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trp_pkg::cmd_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `TRP_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `TRP_ASSERT(a_no_push_when_full, full |-> !push, "push into a full queue")

endmodule

`default_nettype wire

// ===== design/trp_back.sv =====
// Output stage: formats queued commands and holds the result register.
`default_nettype none

module trp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire trp_pkg::cmd_t  head_cmd,
  input  wire logic           queue_empty,
  output logic                pop,
  output logic                result_valid,
  input  wire logic           result_stall,
  output logic [2:0]          kind,
  output logic [3:0]          field_index,
  output logic [7:0]          char_out,
  output logic [8:0]          field_length,
  output logic signed [31:0]  number_value
);

  `include "assert_macros.svh"

  logic        load;
  logic [31:0] number_bits;
  logic        no_number_kind;
  logic        stray_number;

  assign load = !queue_empty && (!result_valid || !result_stall);
  assign pop  = load;

  always_comb begin
    priority if (!head_cmd.is_number) begin
      number_bits = '0;
    end else if (head_cmd.negative) begin
      number_bits = 32'd0 - head_cmd.magnitude;
    end else if (head_cmd.magnitude[31]) begin
      number_bits = trp_pkg::POS_MAX;
    end else begin
      number_bits = head_cmd.magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= head_cmd.kind;
      field_index  <= head_cmd.field_index;
      char_out     <= head_cmd.char_out;
      field_length <= head_cmd.field_length;
      number_value <= number_bits;
    end
  end

  assign no_number_kind = (kind == trp_pkg::KIND_CHAR) || (kind == trp_pkg::KIND_FIELD_END) ||
                          (kind == trp_pkg::KIND_STRAND) || (kind == trp_pkg::KIND_OVERFLOW);
  assign stray_number   = result_valid && no_number_kind && (number_value != '0);

  `TRP_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !result_valid, "result valid right after reset")
  `TRP_ASSERT(a_number_only_where_due, !stray_number, "number on a non-numeric result")

endmodule

`default_nettype wire

// ===== design/tab_separated_record_parser_unit.sv =====
// Top level of the tab-separated record parser.
//
// Input channel: one byte of record text per transaction on byte_in,
// qualified by byte_valid and held off by byte_stall.
// Output channel: at most one result per byte (kind, field_index, char_out,
// field_length, number_value), qualified by result_valid, held by
// result_stall. Bytes that give no result (skipped columns, digits of a
// number, later strand bytes, bytes after an overflow) are absorbed.
// Throughput: one byte per cycle while byte_stall is low, set by the front end that
// updates column, count and the decimal accumulator for every byte.
// Each accepted byte's result is registered in the command queue and then in the
// output register, where result_valid shows it.
// A command queue of QUEUE_DEPTH entries sits between the front end and the
// output register; when the receiver stalls, the output register holds,
// the queue fills, and byte_stall rises once the queue is full.
// Reset clears the column, field state, queue and output valid at once;
// bytes are taken in the cycle after reset falls.
`default_nettype none

module tab_separated_record_parser_unit #(
  parameter int QUEUE_DEPTH = trp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_stall,
  input  wire logic [7:0]    byte_in,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [2:0]         kind,
  output logic [3:0]         field_index,
  output logic [7:0]         char_out,
  output logic [8:0]         field_length,
  output logic signed [31:0] number_value
);

  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;
  trp_pkg::cmd_t  push_cmd;
  trp_pkg::cmd_t  head_cmd;

  trp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_in    (byte_in),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  trp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  trp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_cmd     (head_cmd),
    .queue_empty  (queue_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .field_index  (field_index),
    .char_out     (char_out),
    .field_length (field_length),
    .number_value (number_value)
  );

endmodule

`default_nettype wire
